[sv/hamming_corrector_unit_defines.svh]
// Assertion macros for the Hamming corrector unit.
`ifndef HAMMING_CORRECTOR_UNIT_DEFINES_SVH
`define HAMMING_CORRECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hamming_corrector_unit: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define HC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hamming_corrector_unit: next-cycle check failed");

`endif

[sv/hc_pkg.sv]
// Package with widths, status codes and constant tables of the Hamming corrector.
package hc_pkg;

    localparam int CODE_BITS = 63;
    localparam int LEN_W     = 6;
    localparam int SYN_W     = 6;
    localparam int DATA_BITS = 57;
    localparam int CNT_W     = 6;

    typedef logic [CODE_BITS-1:0] code_word_t;
    typedef logic [DATA_BITS-1:0] data_word_t;
    typedef logic [LEN_W-1:0]     len_t;
    typedef logic [SYN_W-1:0]     syn_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    typedef enum logic [1:0] {
        ST_CLEAN     = 2'd0,
        ST_CORRECTED = 2'd1,
        ST_BEYOND    = 2'd2
    } status_t;

    // Positions (1-based) whose index has syndrome bit b set.
    function automatic code_word_t parity_mask(input logic [2:0] b);
        code_word_t m;
        syn_t       pos;
        m = '0;
        for (int i = 0; i < CODE_BITS; i++) begin
            pos  = SYN_W'(i + 1);
            m[i] = pos[b];
        end
        return m;
    endfunction

    // Bit index in the codeword of data bit k (k-th non power of two position).
    function automatic logic [LEN_W-1:0] data_bit_index(input int k);
        logic [LEN_W-1:0] idx;
        int               cnt;
        int               pos;
        idx = '0;
        cnt = 0;
        for (int i = 0; i < CODE_BITS; i++) begin
            pos = i + 1;
            if ((pos & (pos - 1)) != 0) begin
                if (cnt == k) begin
                    idx = LEN_W'(i);
                end
                cnt = cnt + 1;
            end
        end
        return idx;
    endfunction

    // Length minus the number of powers of two not above it.
    function automatic cnt_t data_count_of(input len_t n);
        cnt_t pw;
        pw = '0;
        for (int p = 0; p < LEN_W; p++) begin
            if ((LEN_W+1)'(1 << p) <= {1'b0, n}) begin
                pw = pw + CNT_W'(1);
            end
        end
        return CNT_W'(n) - pw;
    endfunction

endpackage

[sv/hc_if.sv]
// Valid/ready channel interfaces for codeword items and result items.
interface hc_code_if;
    logic              valid;
    logic              ready;
    hc_pkg::code_word_t codeword;
    hc_pkg::len_t       code_length;

    modport source (output valid, output codeword, output code_length, input ready);
    modport sink   (input valid, input codeword, input code_length, output ready);
endinterface

interface hc_result_if;
    logic               valid;
    logic               ready;
    hc_pkg::syn_t       syndrome;
    hc_pkg::status_t    status;
    hc_pkg::code_word_t corrected_word;
    hc_pkg::data_word_t data_word;
    hc_pkg::cnt_t       data_count;

    modport source (output valid, output syndrome, output status, output corrected_word,
                    output data_word, output data_count, input ready);
    modport sink   (input valid, input syndrome, input status, input corrected_word,
                    input data_word, input data_count, output ready);
endinterface

[sv/hamming_corrector_unit.sv]
// Top level: single-error-correcting Hamming decoder, one codeword item per cycle while result does not stall.
//
//  channel  | role | payload
//  ---------+------+----------------------------------------------------------
//  code     | sink | codeword[63], code_length[6]
//  result   | src  | syndrome[6], status[2], corrected_word[63], data_word[57],
//           |      | data_count[6]
//
// Two register stages: input register, then syndrome/correct/extract logic into
// the result register. Throughput is one item per cycle while result does not stall.
// Reset clears both stage valid flags; payload registers are not reset.
// A stall on result holds the result register and backs up into the input
// register; code.ready drops only when both stages are full and result stalls.
`include "hamming_corrector_unit_defines.svh"

module hamming_corrector_unit
(
    input  logic        clk,
    input  logic        rst_n,
    hc_code_if.sink     code,
    hc_result_if.source result
);

    logic               s1_valid_reg;
    logic               s1_valid_next;
    hc_pkg::code_word_t s1_word_reg;
    hc_pkg::len_t       s1_len_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    hc_pkg::syn_t       syn_reg;
    hc_pkg::status_t    status_reg;
    hc_pkg::code_word_t corr_reg;
    hc_pkg::data_word_t data_reg;
    hc_pkg::cnt_t       count_reg;

    logic               s1_adv;
    logic               code_acc;

    hc_pkg::code_word_t len_mask;
    hc_pkg::code_word_t word;
    hc_pkg::syn_t       syn;
    logic               flip;
    hc_pkg::code_word_t corr;
    hc_pkg::data_word_t data;
    hc_pkg::status_t    status;

    // Handshake and stage control
    assign s1_adv     = s1_valid_reg && (!out_valid_reg || result.ready);
    assign code.ready = !s1_valid_reg || s1_adv;
    assign code_acc   = code.valid && code.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (code_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (code_acc)
        begin
            s1_word_reg <= code.codeword;
            s1_len_reg  <= code.code_length;
        end
    end

    // Decode: a 6-bit length never exceeds the maximum, so no saturation is needed
    always_comb
    begin
        len_mask = ~({hc_pkg::CODE_BITS{1'b1}} << s1_len_reg);
        word     = s1_word_reg & len_mask;

        for (int b = 0; b < hc_pkg::SYN_W; b++)
        begin
            syn[b] = ^(word & hc_pkg::parity_mask(3'(b)));
        end

        flip = (syn != '0) && (syn <= s1_len_reg);
        corr = word;
        if (flip)
        begin
            corr = word ^ (hc_pkg::CODE_BITS'(1) << (syn - hc_pkg::SYN_W'(1)));
        end

        if (syn == '0)
        begin
            status = hc_pkg::ST_CLEAN;
        end
        else if (flip)
        begin
            status = hc_pkg::ST_CORRECTED;
        end
        else
        begin
            status = hc_pkg::ST_BEYOND;
        end

        // Fixed wiring: positions above the length are already zero
        for (int k = 0; k < hc_pkg::DATA_BITS; k++)
        begin
            data[k] = corr[hc_pkg::data_bit_index(k)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            syn_reg    <= syn;
            status_reg <= status;
            corr_reg   <= corr;
            data_reg   <= data;
            count_reg  <= hc_pkg::data_count_of(s1_len_reg);
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.syndrome       = syn_reg;
    assign result.status         = status_reg;
    assign result.corrected_word = corr_reg;
    assign result.data_word      = data_reg;
    assign result.data_count     = count_reg;

    `HC_ASSERT_NEXT(a_out_held, clk, rst_n, out_valid_reg && !result.ready, out_valid_reg)
    `HC_ASSERT_NEXT(a_s1_held, clk, rst_n, s1_valid_reg && !s1_adv, s1_valid_reg)
    `HC_ASSERT_IMPL(a_clean_syn, clk, rst_n,
        out_valid_reg && (status_reg == hc_pkg::ST_CLEAN), syn_reg == '0)
    `HC_ASSERT_IMPL(a_flip_syn, clk, rst_n,
        s1_valid_reg && flip, (corr ^ word) != '0)

endmodule
